### hw/rtl/presence_variance_detector_defines.svh
// Assertion macros shared by the checker of the presence variance detector.
`ifndef PRESENCE_VARIANCE_DETECTOR_DEFINES_SVH
`define PRESENCE_VARIANCE_DETECTOR_DEFINES_SVH

// Same-cycle implication, ignored while reset is applied.
`define PVD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is applied.
`define PVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define PVD_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pvd_pkg.sv
// Shared types and constants of the presence variance detector.
package pvd_pkg;

  localparam int WINDOW_LENGTH_DEF   = 100;
  localparam int MAX_SUBCARRIERS_DEF = 64;
  localparam int MIN_FRAMES          = 10;

  localparam logic [63:0] Q48_MAX  = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] Q32_MAX  = 64'hFFFF_FFFF;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [16:0] CONF_ONE = 17'd65536;

  localparam logic [11:0] PRESENT_RATIO_RST    = 12'd640;
  localparam logic [11:0] ABSENT_RATIO_RST     = 12'd384;
  localparam logic [15:0] QUIET_ADAPT_RATE_RST = 16'd655;
  localparam logic [15:0] DOWN_ADAPT_RATE_RST  = 16'd3277;
  localparam logic [7:0]  WARMUP_FRAMES_RST    = 8'd100;
  localparam logic [19:0] FLOOR_MINIMUM_RST    = 20'd1100;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESENT_RATIO    = 3'd0,
    CFG_ABSENT_RATIO     = 3'd1,
    CFG_QUIET_ADAPT_RATE = 3'd2,
    CFG_DOWN_ADAPT_RATE  = 3'd3,
    CFG_WARMUP_FRAMES    = 3'd4,
    CFG_FLOOR_MINIMUM    = 3'd5
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_SQRT, S_FDIV, S_FDIV_W, S_STORE, S_NCHK, S_SUM_W,
    S_MDIV, S_MDIV_W, S_MSQ, S_DEN_LO, S_DEN_HI, S_VAR, S_VAR_W, S_NV,
    S_NV_W, S_WCHK, S_WDIV, S_WDIV_W, S_RATIO_W, S_DECIDE, S_CONF_W,
    S_PROD_LO, S_PROD_HI, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_SQRT_GO, OP_FDIV_GO, OP_STORE, OP_SUM_GO,
    OP_MDIV_GO, OP_MSQ, OP_DEN_LO, OP_DEN_HI, OP_VAR_GO, OP_NV_GO, OP_WARM,
    OP_WDIV_GO, OP_RATIO_GO, OP_CONF_GO, OP_PROD_LO, OP_PROD_HI, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
    logic pass_busy;
    logic skip;
    logic last;
    logic few;
    logic warmup;
    logic warm_last;
    logic hyst;
    logic out_free;
  } status_t;

endpackage

### hw/rtl/pvd_div.sv
// Serial restoring divider: floor(num * 2^sh / den), saturated to maxv.
module pvd_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [5:0]  sh,
  input  logic [63:0] den,
  input  logic [63:0] maxv,
  output logic        busy,
  output logic        done,
  output logic [63:0] quot
);

  logic        act_r, done_r, ovf_r;
  logic [6:0]  cnt_r, steps_r;
  logic [63:0] num_r, rem_r, q_r, den_r, maxv_r, res_r;
  logic [64:0] rem_sh;
  logic        ge;
  logic [63:0] q_nxt;
  logic        ovf_nxt;

  // After the numerator bits run out, zeros shift in, which supplies the 2^sh factor.
  assign rem_sh  = {rem_r, num_r[63]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign q_nxt   = {q_r[62:0], ge};
  assign ovf_nxt = ovf_r | q_r[63];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        act_r  <= 1'b1;
        cnt_r  <= 7'd0;
        steps_r <= 7'd64 + 7'(sh);
        num_r  <= num;
        rem_r  <= 64'd0;
        q_r    <= 64'd0;
        ovf_r  <= 1'b0;
        den_r  <= den;
        maxv_r <= maxv;
      end else if (act_r) begin
        num_r <= {num_r[62:0], 1'b0};
        rem_r <= ge ? 64'(rem_sh - {1'b0, den_r}) : rem_sh[63:0];
        q_r   <= q_nxt;
        ovf_r <= ovf_nxt;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == steps_r - 7'd1) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
          res_r  <= (ovf_nxt || (q_nxt > maxv_r)) ? maxv_r : q_nxt;
        end
      end
    end
  end

  assign busy = act_r | done_r;
  assign done = done_r;
  assign quot = res_r;

endmodule

### hw/rtl/pvd_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module pvd_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] v,
  output logic        busy,
  output logic        done,
  output logic [15:0] root
);

  logic        act_r, done_r;
  logic [31:0] v_r, r_r, bit_r;
  logic [31:0] trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        act_r <= 1'b1;
        v_r   <= v;
        r_r   <= 32'd0;
        bit_r <= 32'h4000_0000;
      end else if (act_r) begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r == 32'd1) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = act_r | done_r;
  assign done = done_r;
  assign root = r_r[15:0];

endmodule

### hw/rtl/pvd_dp.sv
// Datapath: sample capture, window memory, window passes and decision arithmetic.
module pvd_dp #(
  parameter int WINDOW_LENGTH   = pvd_pkg::WINDOW_LENGTH_DEF,
  parameter int MAX_SUBCARRIERS = pvd_pkg::MAX_SUBCARRIERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pvd_pkg::cmd_t                 cmd,
  output pvd_pkg::status_t              st,
  input  logic [31:0]                   in_tdata,
  input  logic                          in_tlast,
  input  logic                          cfg_wr,
  input  logic [pvd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pvd_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata
);

  localparam int AW  = $clog2(WINDOW_LENGTH);
  localparam int NB  = $clog2(WINDOW_LENGTH + 1);
  localparam int CW  = $clog2(MAX_SUBCARRIERS + 1);
  localparam int MSW = 16 + CW;
  localparam int SW  = 24 + NB;
  localparam int DW  = 48 + NB;

  typedef enum logic [2:0] {
    DST_FMEAN, DST_MEAN, DST_NV, DST_FLOOR, DST_RATIO, DST_CONF
  } dst_t;

  // Configuration registers.
  logic [11:0] pres_ratio_r, abs_ratio_r;
  logic [15:0] quiet_rate_r, down_rate_r;
  logic [7:0]  warm_frames_r;
  logic [19:0] floor_lim_r;

  // Frame and decision state.
  logic signed [15:0] i_r, q_r;
  logic               last_r;
  logic [MSW-1:0]     magsum_r;
  logic [CW-1:0]      subc_r;
  logic [AW-1:0]      wp_r;
  logic               full_r;
  logic [23:0]        fmean_r, m_r;
  logic [47:0]        mm_r, nv_r, floor_r;
  logic [DW-1:0]      den_r, sd_r;
  logic [SW-1:0]      sum_r;
  logic [7:0]         warm_r;
  logic [31:0]        ratio_r;
  logic               pres_r, last_rep_r;
  logic [16:0]        conf_r;
  logic [63:0]        prod_r;
  dst_t               dst_r;

  // Window memory and pass pipeline.
  logic [23:0]        mem [WINDOW_LENGTH];
  logic [23:0]        rdata_r, d_r;
  logic [47:0]        sqd_r;
  logic [AW-1:0]      paddr_r;
  logic               pact_r, pvar_r, v1_r, v2_r, v3_r;

  logic               out_valid_r;
  logic [23:0]        out_data_r;

  logic [NB-1:0]      nfr;
  logic signed [31:0] i_ext, q_ext;
  logic [31:0]        energy;
  logic               sq_go, sq_busy, sq_done;
  logic [15:0]        sq_root;
  logic               div_go, div_busy, div_done;
  logic [63:0]        div_num, div_den, div_maxv, div_q;
  logic [5:0]         div_sh;
  dst_t               div_dst;
  logic [19:0]        pth, ath;
  logic               pres_c, abs_c;
  logic [47:0]        diff, step, floor_adj;
  logic [15:0]        rate;
  logic [NB+23:0]     den_part;
  logic [39:0]        prod_part;
  logic [48:0]        warm_sum;

  assign nfr    = full_r ? NB'(WINDOW_LENGTH) : NB'(wp_r);
  // The squares are formed at full width, so a full-scale negative sample does not wrap.
  assign i_ext  = 32'(i_r);
  assign q_ext  = 32'(q_r);
  assign energy = i_ext * i_ext + q_ext * q_ext;
  assign pth    = {pres_ratio_r, 8'd0};
  assign ath    = {abs_ratio_r, 8'd0};
  assign pres_c = ratio_r > 32'(pth);
  assign abs_c  = ratio_r < 32'(ath);
  assign diff   = (nv_r >= floor_r) ? nv_r - floor_r : floor_r - nv_r;
  assign rate   = !pres_r ? quiet_rate_r : ((nv_r < floor_r) ? down_rate_r : 16'd0);
  assign step   = prod_r[63:16];
  assign floor_adj = (nv_r >= floor_r) ? floor_r + step : floor_r - step;
  assign den_part  = (cmd.op == pvd_pkg::OP_DEN_LO) ? nfr * mm_r[23:0] : nfr * mm_r[47:24];
  assign prod_part = (cmd.op == pvd_pkg::OP_PROD_LO) ? diff[23:0] * rate : diff[47:24] * rate;
  assign warm_sum  = {1'b0, floor_r} + {1'b0, nv_r};
  assign sq_go     = cmd.op == pvd_pkg::OP_SQRT_GO;

  pvd_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_go), .v(energy),
    .busy(sq_busy), .done(sq_done), .root(sq_root)
  );

  always_comb begin
    div_go   = 1'b1;
    div_num  = 64'd0;
    div_sh   = 6'd0;
    div_den  = 64'd1;
    div_maxv = pvd_pkg::ALL_ONES;
    div_dst  = DST_FMEAN;
    case (cmd.op)
      pvd_pkg::OP_FDIV_GO: begin
        div_num = 64'(magsum_r);
        div_sh  = 6'd8;
        div_den = (subc_r == '0) ? 64'd1 : 64'(subc_r);
      end
      pvd_pkg::OP_MDIV_GO: begin
        div_num = 64'(sum_r);
        div_den = 64'(nfr);
        div_dst = DST_MEAN;
      end
      pvd_pkg::OP_NV_GO: begin
        div_num  = 64'(sd_r);
        div_sh   = 6'd40;
        div_den  = (den_r == '0) ? 64'd1 : 64'(den_r);
        div_maxv = pvd_pkg::Q48_MAX;
        div_dst  = DST_NV;
      end
      pvd_pkg::OP_WDIV_GO: begin
        div_num = 64'(floor_r);
        div_den = 64'(warm_frames_r);
        div_dst = DST_FLOOR;
      end
      pvd_pkg::OP_RATIO_GO: begin
        div_num  = 64'(nv_r);
        div_sh   = 6'd16;
        div_den  = (floor_r == '0) ? 64'd1 : 64'(floor_r);
        div_maxv = pvd_pkg::Q32_MAX;
        div_dst  = DST_RATIO;
      end
      pvd_pkg::OP_CONF_GO: begin
        div_sh  = 6'd16;
        div_dst = DST_CONF;
        if (pres_c) begin
          div_go  = pth != 20'd0;
          div_num = 64'(ratio_r - 32'(pth));
          div_den = 64'({pth, 1'b0});
        end else begin
          div_num = 64'(32'(ath) - ratio_r);
          div_den = 64'(ath);
        end
      end
      default: div_go = 1'b0;
    endcase
  end

  pvd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num(div_num), .sh(div_sh),
    .den(div_den), .maxv(div_maxv), .busy(div_busy), .done(div_done), .quot(div_q)
  );

  // Window memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.op == pvd_pkg::OP_STORE) begin
      mem[wp_r] <= fmean_r;
    end
    rdata_r <= mem[paddr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_ratio_r  <= pvd_pkg::PRESENT_RATIO_RST;
      abs_ratio_r   <= pvd_pkg::ABSENT_RATIO_RST;
      quiet_rate_r  <= pvd_pkg::QUIET_ADAPT_RATE_RST;
      down_rate_r   <= pvd_pkg::DOWN_ADAPT_RATE_RST;
      warm_frames_r <= pvd_pkg::WARMUP_FRAMES_RST;
      floor_lim_r   <= pvd_pkg::FLOOR_MINIMUM_RST;
      magsum_r      <= '0;
      subc_r        <= '0;
      wp_r          <= '0;
      full_r        <= 1'b0;
      floor_r       <= 48'd0;
      warm_r        <= 8'd0;
      last_rep_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      pact_r        <= 1'b0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (pvd_pkg::cfg_idx_t'(cfg_index))
          pvd_pkg::CFG_PRESENT_RATIO:    pres_ratio_r  <= cfg_data[11:0];
          pvd_pkg::CFG_ABSENT_RATIO:     abs_ratio_r   <= cfg_data[11:0];
          pvd_pkg::CFG_QUIET_ADAPT_RATE: quiet_rate_r  <= cfg_data[15:0];
          pvd_pkg::CFG_DOWN_ADAPT_RATE:  down_rate_r   <= cfg_data[15:0];
          pvd_pkg::CFG_WARMUP_FRAMES:    warm_frames_r <= cfg_data[7:0];
          pvd_pkg::CFG_FLOOR_MINIMUM:    floor_lim_r   <= cfg_data;
          default: ;
        endcase
      end

      if (sq_done) begin
        magsum_r <= magsum_r + MSW'(sq_root);
        subc_r   <= subc_r + CW'(1);
      end

      if (div_go) begin
        dst_r <= div_dst;
      end
      if (div_done) begin
        case (dst_r)
          DST_FMEAN: fmean_r <= div_q[23:0];
          DST_MEAN:  m_r     <= div_q[23:0];
          DST_NV:    nv_r    <= div_q[47:0];
          DST_FLOOR: floor_r <= div_q[47:0];
          DST_RATIO: ratio_r <= div_q[31:0];
          DST_CONF:  conf_r  <= (div_q > 64'(pvd_pkg::CONF_ONE)) ? pvd_pkg::CONF_ONE
                                                                  : div_q[16:0];
          default: ;
        endcase
      end

      // Window pass: address issue, registered read, then the per-element stages.
      v1_r <= pact_r;
      v2_r <= v1_r && pvar_r;
      v3_r <= v2_r;
      if (pact_r) begin
        if (NB'(paddr_r) == nfr - NB'(1)) begin
          pact_r <= 1'b0;
        end else begin
          paddr_r <= paddr_r + AW'(1);
        end
      end
      if (v1_r) begin
        if (pvar_r) begin
          d_r <= (rdata_r >= m_r) ? rdata_r - m_r : m_r - rdata_r;
        end else begin
          sum_r <= sum_r + SW'(rdata_r);
        end
      end
      if (v2_r) begin
        sqd_r <= d_r * d_r;
      end
      if (v3_r) begin
        sd_r <= sd_r + DW'(sqd_r);
      end

      // A new result may be loaded in the same cycle as the held one leaves.
      if (cmd.op == pvd_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (cmd.op)
        pvd_pkg::OP_CAPTURE: begin
          i_r    <= in_tdata[15:0];
          q_r    <= in_tdata[31:16];
          last_r <= in_tlast;
        end
        pvd_pkg::OP_STORE: begin
          magsum_r <= '0;
          subc_r   <= '0;
          if (NB'(wp_r) + NB'(1) >= NB'(WINDOW_LENGTH)) begin
            wp_r   <= '0;
            full_r <= 1'b1;
          end else begin
            wp_r <= wp_r + AW'(1);
          end
        end
        pvd_pkg::OP_SUM_GO: begin
          pact_r  <= 1'b1;
          paddr_r <= '0;
          pvar_r  <= 1'b0;
          sum_r   <= '0;
        end
        pvd_pkg::OP_VAR_GO: begin
          pact_r  <= 1'b1;
          paddr_r <= '0;
          pvar_r  <= 1'b1;
          sd_r    <= '0;
        end
        pvd_pkg::OP_MSQ:    mm_r  <= m_r * m_r;
        pvd_pkg::OP_DEN_LO: den_r <= DW'(den_part);
        pvd_pkg::OP_DEN_HI: den_r <= den_r + (DW'(den_part) << 24);
        pvd_pkg::OP_WARM: begin
          floor_r <= warm_sum[48] ? pvd_pkg::Q48_MAX[47:0] : warm_sum[47:0];
          warm_r  <= warm_r + 8'd1;
        end
        pvd_pkg::OP_CONF_GO: begin
          pres_r <= pres_c;
          if (pres_c && pth == 20'd0) begin
            conf_r <= pvd_pkg::CONF_ONE;
          end
        end
        pvd_pkg::OP_PROD_LO: prod_r <= 64'(prod_part);
        pvd_pkg::OP_PROD_HI: prod_r <= prod_r + (64'(prod_part) << 24);
        pvd_pkg::OP_EMIT: begin
          floor_r     <= (floor_adj < 48'(floor_lim_r)) ? 48'(floor_lim_r) : floor_adj;
          last_rep_r  <= pres_r;
          out_data_r  <= {5'd0, pres_r != last_rep_r, conf_r, pres_r};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    st.sqrt_busy = sq_busy;
    st.div_busy  = div_busy;
    st.pass_busy = pact_r | v1_r | v2_r | v3_r;
    st.skip      = subc_r >= CW'(MAX_SUBCARRIERS);
    st.last      = last_r;
    st.few       = nfr < NB'(pvd_pkg::MIN_FRAMES);
    st.warmup    = warm_r < warm_frames_r;
    st.warm_last = ({1'b0, warm_r} + 9'd1) == {1'b0, warm_frames_r};
    st.hyst      = !pres_c && !abs_c;
    st.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hw/rtl/pvd_ctrl.sv
// Controller: sequences the datapath through sample and frame processing.
module pvd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  pvd_pkg::status_t st,
  output pvd_pkg::cmd_t    cmd
);

  pvd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pvd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = pvd_pkg::OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      pvd_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = pvd_pkg::OP_CAPTURE;
          state_nxt = pvd_pkg::S_CHECK;
        end
      end
      pvd_pkg::S_CHECK: begin
        if (!st.skip) begin
          cmd.op    = pvd_pkg::OP_SQRT_GO;
          state_nxt = pvd_pkg::S_SQRT;
        end else begin
          state_nxt = st.last ? pvd_pkg::S_FDIV : pvd_pkg::S_IDLE;
        end
      end
      pvd_pkg::S_SQRT: begin
        if (!st.sqrt_busy) state_nxt = st.last ? pvd_pkg::S_FDIV : pvd_pkg::S_IDLE;
      end
      pvd_pkg::S_FDIV: begin
        cmd.op    = pvd_pkg::OP_FDIV_GO;
        state_nxt = pvd_pkg::S_FDIV_W;
      end
      pvd_pkg::S_FDIV_W: if (!st.div_busy) state_nxt = pvd_pkg::S_STORE;
      pvd_pkg::S_STORE: begin
        cmd.op    = pvd_pkg::OP_STORE;
        state_nxt = pvd_pkg::S_NCHK;
      end
      pvd_pkg::S_NCHK: begin
        if (st.few) begin
          state_nxt = pvd_pkg::S_IDLE;
        end else begin
          cmd.op    = pvd_pkg::OP_SUM_GO;
          state_nxt = pvd_pkg::S_SUM_W;
        end
      end
      pvd_pkg::S_SUM_W: if (!st.pass_busy) state_nxt = pvd_pkg::S_MDIV;
      pvd_pkg::S_MDIV: begin
        cmd.op    = pvd_pkg::OP_MDIV_GO;
        state_nxt = pvd_pkg::S_MDIV_W;
      end
      pvd_pkg::S_MDIV_W: if (!st.div_busy) state_nxt = pvd_pkg::S_MSQ;
      pvd_pkg::S_MSQ: begin
        cmd.op    = pvd_pkg::OP_MSQ;
        state_nxt = pvd_pkg::S_DEN_LO;
      end
      pvd_pkg::S_DEN_LO: begin
        cmd.op    = pvd_pkg::OP_DEN_LO;
        state_nxt = pvd_pkg::S_DEN_HI;
      end
      pvd_pkg::S_DEN_HI: begin
        cmd.op    = pvd_pkg::OP_DEN_HI;
        state_nxt = pvd_pkg::S_VAR;
      end
      pvd_pkg::S_VAR: begin
        cmd.op    = pvd_pkg::OP_VAR_GO;
        state_nxt = pvd_pkg::S_VAR_W;
      end
      pvd_pkg::S_VAR_W: if (!st.pass_busy) state_nxt = pvd_pkg::S_NV;
      pvd_pkg::S_NV: begin
        cmd.op    = pvd_pkg::OP_NV_GO;
        state_nxt = pvd_pkg::S_NV_W;
      end
      pvd_pkg::S_NV_W: if (!st.div_busy) state_nxt = pvd_pkg::S_WCHK;
      pvd_pkg::S_WCHK: begin
        if (st.warmup) begin
          cmd.op    = pvd_pkg::OP_WARM;
          state_nxt = st.warm_last ? pvd_pkg::S_WDIV : pvd_pkg::S_IDLE;
        end else begin
          cmd.op    = pvd_pkg::OP_RATIO_GO;
          state_nxt = pvd_pkg::S_RATIO_W;
        end
      end
      pvd_pkg::S_WDIV: begin
        cmd.op    = pvd_pkg::OP_WDIV_GO;
        state_nxt = pvd_pkg::S_WDIV_W;
      end
      pvd_pkg::S_WDIV_W: if (!st.div_busy) state_nxt = pvd_pkg::S_IDLE;
      pvd_pkg::S_RATIO_W: if (!st.div_busy) state_nxt = pvd_pkg::S_DECIDE;
      pvd_pkg::S_DECIDE: begin
        if (st.hyst) begin
          state_nxt = pvd_pkg::S_IDLE;
        end else begin
          cmd.op    = pvd_pkg::OP_CONF_GO;
          state_nxt = pvd_pkg::S_CONF_W;
        end
      end
      pvd_pkg::S_CONF_W: if (!st.div_busy) state_nxt = pvd_pkg::S_PROD_LO;
      pvd_pkg::S_PROD_LO: begin
        cmd.op    = pvd_pkg::OP_PROD_LO;
        state_nxt = pvd_pkg::S_PROD_HI;
      end
      pvd_pkg::S_PROD_HI: begin
        cmd.op    = pvd_pkg::OP_PROD_HI;
        state_nxt = pvd_pkg::S_EMIT;
      end
      pvd_pkg::S_EMIT: begin
        if (st.out_free) begin
          cmd.op    = pvd_pkg::OP_EMIT;
          state_nxt = pvd_pkg::S_IDLE;
        end
      end
      default: state_nxt = pvd_pkg::S_IDLE;
    endcase
  end

endmodule

### hw/rtl/presence_variance_detector.sv
// Top level of the CSI presence variance detector.
//
// The block takes one subcarrier I/Q sample per input transaction and works
// on one sample at a time. An ordinary sample passes through capture, the
// start of the iterative square root, its sixteen steps, its completion and
// the return to idle. The sample flagged by tlast also closes the frame: a
// serial division forms the frame mean, two walks over the window memory
// read the stored frames, and the shared serial divider then forms the
// window mean and the normalised variance. After warm-up the ratio division
// follows and, for a ratio outside the hysteresis band, the confidence
// division; all divisions share the one serial divider, and both walks use
// the single read port of the window memory. The window memory needs no
// clearing pass, since an entry is read only once it has been written. A
// result transaction appears only at a frame end whose ratio lies outside
// the hysteresis band, and it waits in an output register while the next
// samples are already accepted. Configuration writes are always accepted;
// they are meant to be made while the block is idle.
module presence_variance_detector #(
  parameter int WINDOW_LENGTH   = pvd_pkg::WINDOW_LENGTH_DEF,
  parameter int MAX_SUBCARRIERS = pvd_pkg::MAX_SUBCARRIERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // i_sample[15:0], q_sample[31:16]
  input  logic                           in_tlast,   // last_subcarrier
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // present[0], confidence[17:1],
                                                     // changed[18], zero fill [23:19]
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pvd_pkg::CFG_DATA_W-1:0] cfg_data
);

  pvd_pkg::cmd_t    cmd;
  pvd_pkg::status_t st;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  pvd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  pvd_dp #(
    .WINDOW_LENGTH   (WINDOW_LENGTH),
    .MAX_SUBCARRIERS (MAX_SUBCARRIERS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_wr     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### hw/rtl/pvd_checker.sv
// Port-level checker of the presence variance detector, bound to the top level.
`include "presence_variance_detector_defines.svh"

module pvd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [23:0]                    out_tdata
);

  `PVD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `PVD_ASSERT_IMPL(a_conf_cap, out_tvalid, out_tdata[17:1] <= 17'd65536, "confidence above one")
  `PVD_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed while stalled")
  `PVD_ASSERT_RST(a_reset_quiet, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind presence_variance_detector pvd_checker u_pvd_checker (.*);
